// ===== sv/mfb_pkg.sv =====
// mfb_pkg: shared constants, codes and types of the monochrome framebuffer draw engine.
// Used by mfb_store and mono_framebuffer_draw_engine; depends on nothing.
package mfb_pkg;

   // default canvas limits and the byte store they imply
   localparam int MFB_MAX_COLUMNS = 128;
   localparam int MFB_MAX_ROWS    = 64;
   localparam int MFB_DEPTH       = MFB_MAX_COLUMNS * ((MFB_MAX_ROWS + 7) / 8);

   // reset values of the canvas registers
   localparam logic [7:0] CANVAS_WIDTH_RST  = 8'd128;
   localparam logic [6:0] CANVAS_HEIGHT_RST = 7'd64;

   // register indexes on the csr port
   localparam logic CSR_CANVAS_WIDTH  = 1'b0;
   localparam logic CSR_CANVAS_HEIGHT = 1'b1;

   typedef enum logic [1:0] {
      REQ_FILL   = 2'd0,
      REQ_COLUMN = 2'd1,
      REQ_READ   = 2'd2
   } req_code_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SETUP,
      ST_WALK,
      ST_DONE
   } state_type;

   // one read-modify-write step handed to the store
   typedef struct packed {
      logic       rd;
      logic       wr;
      logic [7:0] mask;
      logic [7:0] data;
   } rmw_op_type;

endpackage

// ===== sv/mfb_store.sv =====
// mfb_store: byte store of the framebuffer with a registered synchronous read
// and a merge stage that writes back the modified byte. Depends on mfb_pkg.
module mfb_store import mfb_pkg::*; #(
   parameter int DEPTH = MFB_DEPTH,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              reset,
   input  rmw_op_type        op,
   input  logic [ADDR_W-1:0] op_addr,
   input  logic              clr_en,
   input  logic [ADDR_W-1:0] clr_addr,
   output logic [7:0]        rd_data
);

   logic [7:0]        mem [DEPTH];
   logic [7:0]        rd_data_ff;
   logic              s2_wr_ff;
   logic [ADDR_W-1:0] s2_addr_ff;
   logic [7:0]        s2_mask_ff;
   logic [7:0]        s2_data_ff;
   logic [7:0]        merged;

   assign merged  = (rd_data_ff & ~s2_mask_ff) | (s2_data_ff & s2_mask_ff);
   assign rd_data = rd_data_ff;

   always_ff @(posedge clock) begin
      if (op.rd) begin
         rd_data_ff <= mem[op_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (clr_en) begin
         mem[clr_addr] <= 8'h00;
      end else if (s2_wr_ff) begin
         mem[s2_addr_ff] <= merged;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_wr_ff <= 1'b0;
      end else begin
         s2_wr_ff <= op.rd & op.wr;
      end
   end

   always_ff @(posedge clock) begin
      if (op.rd) begin
         s2_addr_ff <= op_addr;
         s2_mask_ff <= op.mask;
         s2_data_ff <= op.data;
      end
   end

   // write-back must never target the byte being read in the same cycle
   a_no_rmw_overlap: assert property (@(posedge clock) disable iff (reset)
      s2_wr_ff && op.rd |-> op_addr != s2_addr_ff)
      else $error("read issued to the byte under write-back");

   a_clear_alone: assert property (@(posedge clock) disable iff (reset)
      clr_en |-> !op.rd && !s2_wr_ff)
      else $error("clearing pass overlaps a read-modify-write");

   a_wb_follows_read: assert property (@(posedge clock) disable iff (reset)
      s2_wr_ff |-> $past(op.rd))
      else $error("write-back without a preceding read");

endmodule

// ===== sv/mono_framebuffer_draw_engine.sv =====
// mono_framebuffer_draw_engine: 1-bit column-major framebuffer with box fill,
// image column write and byte read. Depends on mfb_pkg and mfb_store.
//
// After reset the block sweeps the byte store to zero, one byte a cycle, and
// req_ready stays low until the sweep ends; csr writes are taken during the
// sweep. Each request then passes the accept, setup, walk and result steps:
// the walk issues one read-modify-write a cycle on the single store port pair,
// one per byte touched. A read touches one byte, an image column up to 8 bytes
// and a box fill columns * byte rows (up to 128 * 8); a rejected or empty
// request skips the walk. A new request is accepted while the previous
// result beat still waits on rsp_ready.
module mono_framebuffer_draw_engine import mfb_pkg::*; #(
   parameter int MAX_COLUMNS = MFB_MAX_COLUMNS,
   parameter int MAX_ROWS    = MFB_MAX_ROWS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [7:0]  csr_wdata,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_type,
   input  logic [7:0]  req_x_origin,
   input  logic [7:0]  req_y_origin,
   input  logic [7:0]  req_span_width,
   input  logic [7:0]  req_span_height,
   input  logic [7:0]  req_col_index,
   input  logic [63:0] req_col_bits,
   input  logic        req_fill_color,
   input  logic        req_invert,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_status,
   output logic [7:0]  rsp_read_byte
);

   localparam int COL_BYTES = (MAX_ROWS + 7) / 8;
   localparam int DEPTH     = MAX_COLUMNS * COL_BYTES;
   localparam int ADDR_W    = $clog2(DEPTH);

   // canvas registers
   logic [7:0] width_ff;
   logic [6:0] height_ff;

   // request beat
   logic [1:0]  type_ff;
   logic [7:0]  x_ff, y_ff, w_ff, h_ff, ci_ff;
   logic [63:0] bits_ff;
   logic        color_ff, inv_ff;

   // walk state
   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic [ADDR_W-1:0] base_ff, base_in;
   logic [7:0]        col_ff, col_in, col_last_ff, col_last_in;
   logic [2:0]        brow_ff, brow_in, brow_first_ff, brow_first_in, brow_last_ff, brow_last_in;
   logic [5:0]        rs_ff, rs_in, re_ff, re_in;
   logic [63:0]       pix_ff, pix_in;
   logic              wr_ff, wr_in, fill_ff, fill_in;
   logic              status_ff, status_in, rd_ok_ff, rd_ok_in;

   // result register
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_status_ff;
   logic [7:0] rsp_byte_ff;
   logic       rsp_load;

   // store interface
   rmw_op_type        op;
   logic [ADDR_W-1:0] op_addr;
   logic              clr_en;
   logic [7:0]        rd_data;

   // geometry
   logic [8:0]  cw, x9, y9, xe9, ye9, ch9, xe_c, ye_c, colx9;
   logic [6:0]  ch;
   logic [3:0]  cb;
   logic [4:0]  yb;
   logic        fill_empty, col_reject, rd_reject;
   logic [8:0]  fill_col_last9, fill_re9, col_re9;
   logic [7:0]  col_sel;
   logic [63:0] pix_sh;
   logic [7:0]  mask;

   assign cw  = ({1'b0, width_ff} > 9'(MAX_COLUMNS)) ? 9'(MAX_COLUMNS) : {1'b0, width_ff};
   assign ch  = (height_ff > 7'(MAX_ROWS)) ? 7'(MAX_ROWS) : height_ff;
   assign cb  = 4'((8'(ch) + 8'd7) >> 3);
   assign ch9 = {2'b00, ch};
   assign x9  = {1'b0, x_ff};
   assign y9  = {1'b0, y_ff};
   assign xe9 = x9 + {1'b0, w_ff};
   assign ye9 = y9 + {1'b0, h_ff};
   assign yb  = y_ff[7:3];

   // box fill is clipped to the canvas
   assign xe_c           = (xe9 > cw) ? cw : xe9;
   assign ye_c           = (ye9 > ch9) ? ch9 : ye9;
   assign fill_empty     = (x9 >= xe_c) || (y9 >= ye_c);
   assign fill_col_last9 = xe_c - 9'd1;
   assign fill_re9       = ye_c - 9'd1;

   // image column must fit whole
   assign colx9      = x9 + {1'b0, ci_ff};
   assign col_reject = (xe9 > cw) || (ye9 > ch9) || (ci_ff >= w_ff);
   assign col_re9    = ye9 - 9'd1;

   assign rd_reject = (x9 >= cw) || (yb >= 5'(cb));

   always_comb begin
      case (req_code_type'(type_ff))
         REQ_COLUMN: col_sel = colx9[7:0];
         default:    col_sel = x_ff;
      endcase
   end

   // byte-row mask over the rows in [rs, re], bit 7 is the top row
   always_comb begin
      for (int k = 0; k < 8; k++) begin
         mask[7-k] = ({brow_ff, 3'(k)} >= rs_ff) && ({brow_ff, 3'(k)} <= re_ff);
      end
   end

   assign pix_sh = pix_ff << {brow_ff, 3'b000};

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      base_in       = base_ff;
      col_in        = col_ff;
      col_last_in   = col_last_ff;
      brow_in       = brow_ff;
      brow_first_in = brow_first_ff;
      brow_last_in  = brow_last_ff;
      rs_in         = rs_ff;
      re_in         = re_ff;
      pix_in        = pix_ff;
      wr_in         = wr_ff;
      fill_in       = fill_ff;
      status_in     = status_ff;
      rd_ok_in      = rd_ok_ff;
      op            = '0;
      op_addr       = base_ff + ADDR_W'(brow_ff);
      clr_en        = 1'b0;
      rsp_load      = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            clr_en = 1'b1;
            clr_in = clr_ff + ADDR_W'(1);
            if (clr_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            base_in  = ADDR_W'(12'(col_sel) * 12'(cb));
            col_in   = col_sel;
            pix_in   = (bits_ff >> y_ff[5:0]) ^ {64{inv_ff}};
            rs_in    = y_ff[5:0];
            rd_ok_in = 1'b0;
            case (req_code_type'(type_ff))
               REQ_FILL: begin
                  wr_in         = 1'b1;
                  fill_in       = 1'b1;
                  status_in     = 1'b0;
                  col_last_in   = fill_col_last9[7:0];
                  brow_in       = y_ff[5:3];
                  brow_first_in = y_ff[5:3];
                  brow_last_in  = fill_re9[5:3];
                  re_in         = fill_re9[5:0];
                  state_in      = fill_empty ? ST_DONE : ST_WALK;
               end
               REQ_COLUMN: begin
                  wr_in         = 1'b1;
                  fill_in       = 1'b0;
                  status_in     = col_reject;
                  col_last_in   = colx9[7:0];
                  brow_in       = y_ff[5:3];
                  brow_first_in = y_ff[5:3];
                  brow_last_in  = col_re9[5:3];
                  re_in         = col_re9[5:0];
                  state_in      = (col_reject || h_ff == 8'd0) ? ST_DONE : ST_WALK;
               end
               REQ_READ: begin
                  wr_in         = 1'b0;
                  fill_in       = 1'b0;
                  status_in     = rd_reject;
                  rd_ok_in      = !rd_reject;
                  col_last_in   = x_ff;
                  brow_in       = yb[2:0];
                  brow_first_in = yb[2:0];
                  brow_last_in  = yb[2:0];
                  state_in      = rd_reject ? ST_DONE : ST_WALK;
               end
               default: begin
                  wr_in     = 1'b0;
                  fill_in   = 1'b0;
                  status_in = 1'b1;
                  state_in  = ST_DONE;
               end
            endcase
         end
         ST_WALK: begin
            op.rd   = 1'b1;
            op.wr   = wr_ff;
            op.mask = mask;
            op.data = fill_ff ? {8{color_ff}} : pix_sh[63:56];
            if (brow_ff == brow_last_ff) begin
               if (fill_ff && col_ff != col_last_ff) begin
                  col_in  = col_ff + 8'd1;
                  base_in = base_ff + ADDR_W'(cb);
                  brow_in = brow_first_ff;
               end else begin
                  state_in = ST_DONE;
               end
            end else begin
               brow_in = brow_ff + 3'd1;
            end
         end
         ST_DONE: begin
            // last write-back lands in the first cycle here
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         width_ff     <= CANVAS_WIDTH_RST;
         height_ff    <= CANVAS_HEIGHT_RST;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we && csr_index == CSR_CANVAS_WIDTH) begin
            width_ff <= csr_wdata;
         end
         if (csr_we && csr_index == CSR_CANVAS_HEIGHT) begin
            height_ff <= csr_wdata[6:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      base_ff       <= base_in;
      col_ff        <= col_in;
      col_last_ff   <= col_last_in;
      brow_ff       <= brow_in;
      brow_first_ff <= brow_first_in;
      brow_last_ff  <= brow_last_in;
      rs_ff         <= rs_in;
      re_ff         <= re_in;
      pix_ff        <= pix_in;
      wr_ff         <= wr_in;
      fill_ff       <= fill_in;
      status_ff     <= status_in;
      rd_ok_ff      <= rd_ok_in;
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         type_ff  <= req_type;
         x_ff     <= req_x_origin;
         y_ff     <= req_y_origin;
         w_ff     <= req_span_width;
         h_ff     <= req_span_height;
         ci_ff    <= req_col_index;
         bits_ff  <= req_col_bits;
         color_ff <= req_fill_color;
         inv_ff   <= req_invert;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_byte_ff   <= rd_ok_ff ? rd_data : 8'h00;
      end
   end

   assign req_ready     = (state_ff == ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_read_byte = rsp_byte_ff;

   mfb_store #(
      .DEPTH (DEPTH)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .op       (op),
      .op_addr  (op_addr),
      .clr_en   (clr_en),
      .clr_addr (clr_ff),
      .rd_data  (rd_data)
   );

   a_result_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> rsp_valid)
      else $error("result not presented after completion");

   a_walk_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WALK |-> col_ff <= col_last_ff && brow_ff <= brow_last_ff)
      else $error("walk left its column or byte-row range");

   a_pipe_empty_on_accept: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !$past(op.rd))
      else $error("new request taken with a store access in flight");

   a_no_walk_on_reject: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WALK |-> !status_ff)
      else $error("rejected request touches the store");

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// tb_top: self-checking bench for mono_framebuffer_draw_engine: box fill, image column
// write and byte read against a byte-level canvas copy. Depends on mfb_pkg and the RTL.
module tb_top import mfb_pkg::*; ();

   localparam logic [1:0] REQ_UNKNOWN    = 2'd3;
   localparam int         IMAGE_ROWS_MAX = 64;
   localparam int         HOLD_CYCLES    = 400;
   localparam int         SETTLE_CYCLES  = 8;
   localparam int         MAX_REPORTS    = 10;
   localparam int         RANDOM_PHASES  = 12;
   localparam int         PHASE_ITEMS    = 105;
   localparam int         PRESSURE_ITEMS = 40;

   typedef struct {
      logic [1:0]  kind;
      logic [7:0]  x, y, w, h, ci;
      logic [63:0] bits;
      logic        color, inv;
   } draw_req_type;

   typedef struct {
      logic       status;
      logic [7:0] rbyte;
   } draw_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic        csr_index = 1'b0;
   logic [7:0]  csr_wdata = 8'h00;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_type = 2'd0;
   logic [7:0]  req_x_origin = 8'h00;
   logic [7:0]  req_y_origin = 8'h00;
   logic [7:0]  req_span_width = 8'h00;
   logic [7:0]  req_span_height = 8'h00;
   logic [7:0]  req_col_index = 8'h00;
   logic [63:0] req_col_bits = 64'h0;
   logic        req_fill_color = 1'b0;
   logic        req_invert = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_status;
   logic [7:0]  rsp_read_byte;

   // canvas copy and register copies
   logic [7:0]   frame_bytes [MFB_DEPTH];
   logic [7:0]   canvas_w_cfg = CANVAS_WIDTH_RST;
   logic [6:0]   canvas_h_cfg = CANVAS_HEIGHT_RST;
   draw_rsp_type pending_rsp_q [$];
   int           error_count = 0;
   int           rsp_seen = 0;

   // sender burst control, gap_max of 0 keeps valid up back to back
   int          gap_max = 0;
   int          burst_left = 0;

   // receiver control: a set mask bit drops ready in that slot
   logic [15:0] stall_mask = 16'h0000;
   logic [3:0]  stall_phase = 4'd0;
   logic        hold_trigger = 1'b0;
   int          hold_left = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   mono_framebuffer_draw_engine u_top (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_x_origin    (req_x_origin),
      .req_y_origin    (req_y_origin),
      .req_span_width  (req_span_width),
      .req_span_height (req_span_height),
      .req_col_index   (req_col_index),
      .req_col_bits    (req_col_bits),
      .req_fill_color  (req_fill_color),
      .req_invert      (req_invert),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_read_byte   (rsp_read_byte)
   );

   function automatic int used_cols();
      return (canvas_w_cfg > MFB_MAX_COLUMNS) ? MFB_MAX_COLUMNS : int'(canvas_w_cfg);
   endfunction

   function automatic int used_rows();
      return (canvas_h_cfg > MFB_MAX_ROWS) ? MFB_MAX_ROWS : int'(canvas_h_cfg);
   endfunction

   function automatic void paint_pixel(int col, int row, int col_bytes, logic lit);
      int         addr;
      logic [7:0] mask;
      addr = col * col_bytes + row / 8;
      mask = 8'h80 >> (row % 8);
      if (addr < MFB_DEPTH) begin
         if (lit) frame_bytes[addr] = frame_bytes[addr] | mask;
         else frame_bytes[addr] = frame_bytes[addr] & ~mask;
      end
   endfunction

   // applies one request to the canvas copy and returns its result beat
   function automatic draw_rsp_type draw_predict(draw_req_type r);
      draw_rsp_type res;
      int           cols, rows, col_bytes, x_end, y_end, yb, addr;
      cols = used_cols();
      rows = used_rows();
      col_bytes = (rows + 7) / 8;
      res.status = 1'b0;
      res.rbyte = 8'h00;
      case (r.kind)
         REQ_FILL: begin
            x_end = int'(r.x) + int'(r.w);
            y_end = int'(r.y) + int'(r.h);
            if (x_end > cols) x_end = cols;
            if (y_end > rows) y_end = rows;
            for (int c = int'(r.x); c < x_end; c++)
               for (int row = int'(r.y); row < y_end; row++)
                  paint_pixel(c, row, col_bytes, r.color);
         end
         REQ_COLUMN: begin
            // the whole image has to fit, not just the column carried
            if (int'(r.x) + int'(r.w) > cols || int'(r.y) + int'(r.h) > rows ||
                r.ci >= r.w || r.h > IMAGE_ROWS_MAX) begin
               res.status = 1'b1;
            end else begin
               for (int i = 0; i < int'(r.h); i++)
                  paint_pixel(int'(r.x) + int'(r.ci), int'(r.y) + i, col_bytes,
                              r.bits[63 - i] ^ r.inv);
            end
         end
         REQ_READ: begin
            yb = int'(r.y) / 8;
            addr = int'(r.x) * col_bytes + yb;
            if (int'(r.x) >= cols || yb >= col_bytes || addr >= MFB_DEPTH) res.status = 1'b1;
            else res.rbyte = frame_bytes[addr];
         end
         default: begin
            res.status = 1'b1;
         end
      endcase
      return res;
   endfunction

   function automatic void flag_error(string msg);
      error_count++;
      if (error_count <= MAX_REPORTS) $display("%s", msg);
   endfunction

   always @(posedge clock) begin
      if (hold_trigger) begin
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         stall_phase <= stall_phase + 4'd1;
         rsp_ready <= !stall_mask[stall_phase];
      end
   end

   always @(posedge clock) begin
      draw_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp_q.size() == 0) begin
            flag_error($sformatf("beat %0d: result with nothing pending (status %0b byte %02h)",
                                 rsp_seen, rsp_status, rsp_read_byte));
         end else begin
            want = pending_rsp_q.pop_front();
            if (rsp_status !== want.status)
               flag_error($sformatf("beat %0d: status expected %0b got %0b",
                                    rsp_seen, want.status, rsp_status));
            if (rsp_read_byte !== want.rbyte)
               flag_error($sformatf("beat %0d: read_byte expected %02h got %02h",
                                    rsp_seen, want.rbyte, rsp_read_byte));
         end
         rsp_seen++;
      end
   end

   function automatic draw_req_type mk_req(logic [1:0] kind, logic [7:0] x, logic [7:0] y,
                                           logic [7:0] w, logic [7:0] h, logic [7:0] ci,
                                           logic [63:0] bits, logic color, logic inv);
      draw_req_type r;
      r.kind = kind;
      r.x = x;
      r.y = y;
      r.w = w;
      r.h = h;
      r.ci = ci;
      r.bits = bits;
      r.color = color;
      r.inv = inv;
      return r;
   endfunction

   task automatic send_req(draw_req_type r);
      int gap;
      req_type <= r.kind;
      req_x_origin <= r.x;
      req_y_origin <= r.y;
      req_span_width <= r.w;
      req_span_height <= r.h;
      req_col_index <= r.ci;
      req_col_bits <= r.bits;
      req_fill_color <= r.color;
      req_invert <= r.inv;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_ready !== 1'b1);
      pending_rsp_q.push_back(draw_predict(r));
      if (gap_max > 0) begin
         if (burst_left > 0) begin
            burst_left--;
         end else begin
            gap = $urandom_range(1, gap_max);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
            burst_left = $urandom_range(0, 12);
         end
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_rsp_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // only called with the engine idle; writes both registers back to back
   task automatic set_canvas(logic [7:0] width_val, logic [7:0] height_val);
      csr_we <= 1'b1;
      csr_index <= CSR_CANVAS_WIDTH;
      csr_wdata <= width_val;
      @(posedge clock);
      csr_index <= CSR_CANVAS_HEIGHT;
      csr_wdata <= height_val;
      @(posedge clock);
      csr_we <= 1'b0;
      canvas_w_cfg = width_val;
      canvas_h_cfg = height_val[6:0];
   endtask

   function automatic draw_req_type random_req();
      draw_req_type r;
      int           cols, rows, pick;
      cols = used_cols();
      rows = used_rows();
      pick = $urandom_range(0, 99);
      r.kind = 2'($urandom());
      r.x = 8'($urandom());
      r.y = 8'($urandom());
      r.w = 8'($urandom());
      r.h = 8'($urandom());
      r.ci = 8'($urandom());
      r.bits = {$urandom(), $urandom()};
      r.color = 1'($urandom());
      r.inv = 1'($urandom());
      if (pick < 4) begin
         r.kind = REQ_UNKNOWN;
      end else if (pick < 12) begin
         // raw noise, any request code
      end else if (pick < 42) begin
         r.kind = REQ_COLUMN;
         if (cols > 0) begin
            r.w = 8'($urandom_range(1, cols));
            r.x = 8'($urandom_range(0, cols - int'(r.w)));
            r.h = 8'($urandom_range(0, rows));
            r.y = 8'($urandom_range(0, rows - int'(r.h)));
            r.ci = 8'($urandom_range(0, int'(r.w) - 1));
         end
      end else if (pick < 72) begin
         r.kind = REQ_FILL;
         // mostly small boxes near the canvas so fills stay short
         if (pick < 68) begin
            r.x = 8'($urandom_range(0, cols + 2));
            r.y = 8'($urandom_range(0, rows + 2));
            r.w = 8'($urandom_range(0, 12));
            r.h = 8'($urandom_range(0, 12));
         end
      end else begin
         r.kind = REQ_READ;
         r.x = 8'($urandom_range(0, cols));
         r.y = 8'($urandom_range(0, rows + 7));
      end
      return r;
   endfunction

   task automatic test_basic_requests();
      gap_max = 6;
      stall_mask <= 16'h0A31;
      send_req(mk_req(REQ_READ, 0, 0, 0, 0, 0, 64'h0, 0, 0));
      // box far beyond the canvas, clipped to all of it
      send_req(mk_req(REQ_FILL, 0, 0, 255, 255, 0, 64'h0, 1, 0));
      send_req(mk_req(REQ_READ, 127, 56, 0, 0, 0, 64'h0, 0, 0));
      send_req(mk_req(REQ_READ, 128, 0, 0, 0, 0, 64'h0, 0, 0));
      send_req(mk_req(REQ_READ, 0, 64, 0, 0, 0, 64'h0, 0, 0));
      send_req(mk_req(REQ_READ, 255, 255, 255, 255, 255, '1, 1, 1));
      send_req(mk_req(REQ_COLUMN, 10, 0, 1, 64, 0, 64'hA5F0_0FFF_0000_1234, 0, 0));
      send_req(mk_req(REQ_COLUMN, 0, 0, 128, 64, 127, '1, 0, 1));
      send_req(mk_req(REQ_READ, 10, 24, 0, 0, 0, 64'h0, 0, 0));
      send_req(mk_req(REQ_READ, 127, 0, 0, 0, 0, 64'h0, 0, 0));
      // image does not fit, column outside image, zero width
      send_req(mk_req(REQ_COLUMN, 120, 0, 9, 8, 0, '1, 0, 0));
      send_req(mk_req(REQ_COLUMN, 0, 60, 4, 5, 0, '1, 0, 0));
      send_req(mk_req(REQ_COLUMN, 0, 0, 4, 8, 4, 64'h0, 0, 1));
      send_req(mk_req(REQ_COLUMN, 0, 0, 0, 8, 0, 64'h0, 0, 1));
      // zero height image sitting on the bottom edge changes nothing
      send_req(mk_req(REQ_COLUMN, 3, 64, 1, 0, 0, 64'h0, 0, 1));
      send_req(mk_req(REQ_COLUMN, 0, 0, 1, 65, 0, '1, 0, 0));
      send_req(mk_req(REQ_UNKNOWN, 255, 255, 255, 255, 255, '1, 1, 1));
      send_req(mk_req(REQ_FILL, 4, 4, 0, 5, 0, 64'h0, 0, 0));
      send_req(mk_req(REQ_FILL, 5, 3, 3, 10, 0, 64'h0, 0, 0));
      send_req(mk_req(REQ_READ, 5, 0, 0, 0, 0, 64'h0, 0, 0));
      send_req(mk_req(REQ_READ, 6, 8, 0, 0, 0, 64'h0, 0, 0));
      send_req(mk_req(REQ_FILL, 255, 255, 255, 255, 0, 64'h0, 0, 0));
      send_req(mk_req(REQ_COLUMN, 127, 1, 1, 63, 0, 64'h5A3C_C3A5_0FF0_9669, 0, 1));
      send_req(mk_req(REQ_READ, 127, 56, 0, 0, 0, 64'h0, 0, 0));
      drain();
   endtask

   task automatic test_canvas_geometry();
      gap_max = 0;
      stall_mask <= 16'h0000;
      // both registers above the limits, clamped to the full store
      set_canvas(8'd255, 8'hFF);
      send_req(mk_req(REQ_COLUMN, 127, 0, 1, 64, 0, 64'h8000_0000_0000_0001, 0, 0));
      send_req(mk_req(REQ_READ, 127, 56, 0, 0, 0, 64'h0, 0, 0));
      drain();
      set_canvas(8'd0, 8'd0);
      send_req(mk_req(REQ_FILL, 0, 0, 255, 255, 0, 64'h0, 1, 0));
      send_req(mk_req(REQ_READ, 0, 0, 0, 0, 0, 64'h0, 0, 0));
      send_req(mk_req(REQ_COLUMN, 0, 0, 1, 0, 0, 64'h0, 0, 0));
      drain();
      // stored bytes stay put and are read back under the narrower layout
      set_canvas(8'd17, 8'd13);
      send_req(mk_req(REQ_READ, 3, 8, 0, 0, 0, 64'h0, 0, 0));
      send_req(mk_req(REQ_COLUMN, 0, 0, 17, 13, 16, 64'hF0F0_0000_0000_0000, 0, 0));
      send_req(mk_req(REQ_READ, 16, 8, 0, 0, 0, 64'h0, 0, 0));
      drain();
      set_canvas(8'd1, 8'd1);
      send_req(mk_req(REQ_FILL, 0, 0, 1, 1, 0, 64'h0, 1, 0));
      send_req(mk_req(REQ_READ, 0, 0, 0, 0, 0, 64'h0, 0, 0));
      drain();
   endtask

   task automatic test_result_backpressure();
      set_canvas(8'd128, 8'd64);
      gap_max = 0;
      stall_mask <= 16'h0000;
      hold_trigger <= 1'b1;
      @(posedge clock);
      hold_trigger <= 1'b0;
      // sender keeps offering while the result side is held off
      repeat (PRESSURE_ITEMS) send_req(random_req());
      drain();
   endtask

   task automatic test_random_traffic();
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: set_canvas(8'd128, 8'd64);
            1: set_canvas(8'd255, 8'd127);
            2: set_canvas(8'd1, 8'd1);
            3: set_canvas(8'd0, 8'd0);
            4: set_canvas(8'd128, 8'd1);
            5: set_canvas(8'd1, 8'd64);
            default: set_canvas(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)));
         endcase
         burst_left = 0;
         if (phase % 3 == 0) begin
            gap_max = 0;
            stall_mask <= 16'h0000;
         end else begin
            gap_max = $urandom_range(1, 20);
            stall_mask <= 16'($urandom()) & 16'h7FFF;
         end
         repeat (PHASE_ITEMS) send_req(random_req());
         drain();
      end
   endtask

   initial begin
      foreach (frame_bytes[i]) frame_bytes[i] = 8'h00;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_basic_requests();
      test_canvas_geometry();
      test_result_backpressure();
      test_random_traffic();
      if (error_count == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

   initial begin
      #50ms;
      $display("tb_top: errors");
      $finish;
   end

endmodule
